// ===== hdl/qat_pkg.sv =====
package qat_pkg;

	// Limits of one string.
	localparam int MAX_ARGS    = 32;
	localparam int MAX_ARG_LEN = 256;

	// Argument count reaches MAX_ARGS, position stays below MAX_ARG_LEN.
	localparam int CNT_W = $clog2(MAX_ARGS + 1);
	localparam int POS_W = $clog2(MAX_ARG_LEN);

	// Characters with a meaning of their own.
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_BAD_QUOTE = 3'd1,
		ERR_UNCLOSED  = 3'd2,
		ERR_DANGLING  = 3'd3,
		ERR_TOO_MANY  = 3'd4,
		ERR_TOO_LONG  = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0] ch;
		logic [7:0] next_ch;
		logic       is_last;
	} qat_in_t;

	typedef struct packed {
		logic       char_valid;
		logic [7:0] out_char;
		logic       token_end;
		logic [5:0] token_number;
		logic [7:0] char_position;
		logic       done_res;
		logic [2:0] status;
	} qat_out_t;

	// Running parse state carried from one character to the next.
	typedef struct packed {
		logic             inside_token;
		logic             inside_quotes;
		logic             escape_pending;
		logic [7:0]       open_quote_char;
		logic [CNT_W-1:0] token_count;
		logic [POS_W-1:0] position_in_token;
		status_t          first_error;
	} qat_state_t;

endpackage

// ===== hdl/quoted_argument_tokenizer.sv =====
// Flow: a request accepted is held in the input register, then moves into the
// result register, from which it is taken.
// Throughput: one character per cycle while results are taken; a stalled result
// holds in the output register while one more character waits in the input register.
// Reset: arst_n low clears both registers' valid flags and the parse state at once;
// the block then starts a fresh string.
module quoted_argument_tokenizer
	import qat_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  qat_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output qat_out_t out_data
);

	// Input register: holds one request until the step logic can retire it.
	logic       valid_s1;
	qat_in_t    data_s1;

	// Result register, which is also the port payload.
	logic       valid_s2;
	qat_out_t   res_s2;

	// Parse state, updated only when a request moves into the result register.
	qat_state_t state_q;
	qat_state_t state_nxt;
	qat_out_t   res_nxt;
	logic       advance;

	// The request in stage one moves on whenever the result register is free or
	// is being emptied in this same cycle, so a result taken this cycle costs no
	// bubble. A result that waits while stage one is full holds off new requests.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	qat_step u_step (
		.item (data_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

endmodule

// ===== hdl/qat_step.sv =====
module qat_step
	import qat_pkg::*;
(
	input  qat_in_t    item,
	input  qat_state_t cur,
	output qat_state_t nxt,
	output qat_out_t   res
);

	logic       is_blank;
	logic       is_quote;
	logic       do_app;
	logic       do_close;
	logic [7:0] app_c;
	qat_state_t st;

	assign is_blank = (item.ch == CH_SPACE) || (item.ch == CH_TAB) || (item.ch == CH_NL);
	assign is_quote = (item.ch == CH_SQUOTE) || (item.ch == CH_DQUOTE);

	always_comb begin
		st       = cur;
		do_app   = 1'b0;
		do_close = 1'b0;
		app_c    = item.ch;
		res      = '0;

		// Classify the character; at most one append or one close results.
		if (is_blank) begin
			if (st.inside_token) begin
				if (st.escape_pending) begin
					st.escape_pending = 1'b0;
					do_app = 1'b1;
				end else if (st.inside_quotes) begin
					do_app = 1'b1;
				end else begin
					do_close = 1'b1;
				end
			end
		end else if (is_quote) begin
			if (st.escape_pending) begin
				st.escape_pending = 1'b0;
				do_app = 1'b1;
			end else if (!st.inside_token) begin
				st.inside_token    = 1'b1;
				st.inside_quotes   = 1'b1;
				st.open_quote_char = item.ch;
			end else if (st.inside_quotes) begin
				if (item.ch == st.open_quote_char) begin
					do_close = 1'b1;
				end else begin
					do_app = 1'b1;
				end
			end else if (st.first_error == ERR_NONE) begin
				st.first_error = ERR_BAD_QUOTE;
			end
		end else if (item.ch == CH_BSLASH) begin
			if (st.escape_pending) begin
				st.escape_pending = 1'b0;
				do_app = 1'b1;
			end else if (st.inside_quotes && (item.next_ch != st.open_quote_char)) begin
				do_app = 1'b1;
			end else begin
				st.escape_pending = 1'b1;
				st.inside_token   = 1'b1;
			end
		end else begin
			st.inside_token = 1'b1;
			do_app = 1'b1;
		end

		if (do_app) begin
			if (st.token_count >= CNT_W'(MAX_ARGS)) begin
				if (st.first_error == ERR_NONE) st.first_error = ERR_TOO_MANY;
			end else if (st.position_in_token >= POS_W'(MAX_ARG_LEN - 1)) begin
				if (st.first_error == ERR_NONE) st.first_error = ERR_TOO_LONG;
			end else begin
				res.char_valid       = 1'b1;
				res.out_char         = app_c;
				res.char_position    = 8'(st.position_in_token);
				st.position_in_token = st.position_in_token + 1'b1;
			end
		end

		// End of string: an open quote or a pending escape is an error, otherwise an
		// open plain argument closes here. A close already taken leaves nothing open.
		if (item.is_last && !do_close) begin
			if (st.inside_quotes) begin
				if (st.first_error == ERR_NONE) st.first_error = ERR_UNCLOSED;
			end else if (st.escape_pending) begin
				if (st.first_error == ERR_NONE) st.first_error = ERR_DANGLING;
			end else if (st.inside_token) begin
				do_close = 1'b1;
			end
		end

		// The number shown is the argument index before any close, except on the last item.
		res.token_number = 6'(cur.token_count);

		if (do_close) begin
			st.inside_token      = 1'b0;
			st.inside_quotes     = 1'b0;
			st.position_in_token = '0;
			res.token_end        = 1'b1;
			if (st.token_count >= CNT_W'(MAX_ARGS)) begin
				if (st.first_error == ERR_NONE) st.first_error = ERR_TOO_MANY;
			end else begin
				st.token_count = st.token_count + 1'b1;
			end
		end

		res.done_res = item.is_last;
		if (item.is_last) begin
			res.token_number = 6'(st.token_count);
			res.status       = st.first_error;
			nxt              = '0;
		end else begin
			nxt = st;
		end
	end

endmodule

// ===== hdl/qat_checker.sv =====
module qat_checker
	import qat_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input qat_in_t  in_data,
	input logic     out_valid,
	input logic     out_ready,
	input qat_out_t out_data
);

	// A waiting request must stay put until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("request dropped or changed while waiting");

	// A stalled result must stay put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Status is reported only on the last character of a string.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.done_res |-> out_data.status == ERR_NONE)
		else $error("status on a non-final result");

	// Nothing appended means no character and no position.
	a_empty_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.char_valid |-> out_data.out_char == 8'd0
			&& out_data.char_position == 8'd0)
		else $error("stray character on an empty result");

	// Codes and counts stay within their ranges.
	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status <= ERR_TOO_LONG
			&& out_data.token_number <= 6'(MAX_ARGS))
		else $error("status or argument number out of range");

endmodule

bind quoted_argument_tokenizer qat_checker u_qat_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
